[src/strided_nd_index_odometer_assert.svh]
// Assertion macros shared by the odometer modules.
`ifndef STRIDED_ND_INDEX_ODOMETER_ASSERT_SVH
`define STRIDED_ND_INDEX_ODOMETER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SNIO_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SNIO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/snio_pkg.sv]
package snio_pkg;

    // Default sizing
    localparam int unsigned SNIO_MAX_DIMS   = 8;
    localparam int unsigned SNIO_INDEX_BITS = 32;

    // Fixed field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned DIM_IDX_W = 3;
    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned RANK_W    = 4;
    localparam int unsigned OFFSET_W  = 64;

    // Packed stream widths (rounded up to whole bytes)
    localparam int unsigned S_TDATA_RAW = DIM_IDX_W + 5 * FIELD_W;
    localparam int unsigned S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int unsigned M_TDATA_RAW = 2 * OFFSET_W + 2;
    localparam int unsigned M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

    // Command codes
    typedef logic [CMD_W-1:0] cmd_code_t;
    localparam cmd_code_t CMD_LOAD    = 2'd0;
    localparam cmd_code_t CMD_RESTART = 2'd1;
    localparam cmd_code_t CMD_STEP    = 2'd2;

    // Multiply sequence phases
    localparam int unsigned MUL_PH_W = 3;
    typedef logic [MUL_PH_W-1:0] mul_phase_t;
    localparam mul_phase_t MUL_PH_LO     = 3'd0;
    localparam mul_phase_t MUL_PH_X1     = 3'd1;
    localparam mul_phase_t MUL_PH_X2     = 3'd2;
    localparam mul_phase_t MUL_PH_SUM    = 3'd3;
    localparam mul_phase_t MUL_PH_COMMIT = 3'd4;

    // Multiply operand selection
    localparam logic MUL_DECL = 1'b0;
    localparam logic MUL_MEM  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_we;
        logic       restart;
        logic       step_start;
        logic       rd_en;
        logic       chk;
        logic       div_init;
        logic       div_step;
        logic       mul_en;
        mul_phase_t mul_phase;
        logic       mul_sel;
        logic       adv_apply;
        logic       out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic more;
        logic adv_hit;
        logic out_busy;
    } dp_sts_t;

endpackage

[src/snio_dpath.sv]
`include "strided_nd_index_odometer_assert.svh"

module snio_dpath #(
    parameter int unsigned MAX_DIMS   = snio_pkg::SNIO_MAX_DIMS,
    parameter int unsigned INDEX_BITS = snio_pkg::SNIO_INDEX_BITS,
    parameter int unsigned DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  snio_pkg::dp_cmd_t                 cmd,
    input  logic [DIM_W-1:0]                  dim_addr,
    output snio_pkg::dp_sts_t                 sts,
    input  logic [snio_pkg::DIM_IDX_W-1:0]    s_dim_index,
    input  logic [snio_pkg::FIELD_W-1:0]      s_dim_start,
    input  logic [snio_pkg::FIELD_W-1:0]      s_dim_stride,
    input  logic [snio_pkg::FIELD_W-1:0]      s_dim_stop,
    input  logic [snio_pkg::FIELD_W-1:0]      s_dim_declared_size,
    input  logic signed [snio_pkg::FIELD_W-1:0] s_dim_mem_step,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [snio_pkg::OFFSET_W-1:0]     m_declared_offset,
    output logic [snio_pkg::OFFSET_W-1:0]     m_memory_offset,
    output logic                              m_more,
    output logic                              m_advanced
);
    import snio_pkg::*;

    localparam int unsigned IB      = INDEX_BITS;
    localparam int unsigned PARAM_W = 4 * IB + FIELD_W;
    localparam int unsigned OFF_START  = 0;
    localparam int unsigned OFF_STRIDE = IB;
    localparam int unsigned OFF_STOP   = 2 * IB;
    localparam int unsigned OFF_SIZE   = 3 * IB;
    localparam int unsigned OFF_STEP   = 4 * IB;

    // Dimension tables
    logic [PARAM_W-1:0] param_mem [MAX_DIMS];
    logic [IB:0]        idx_mem   [MAX_DIMS];
    logic [MAX_DIMS-1:0] param_valid_reg;
    logic [MAX_DIMS-1:0] at_start_reg;

    // Registered read of one dimension
    logic [PARAM_W-1:0] rd_param_reg;
    logic [IB:0]        rd_idx_reg;
    logic               rd_pvalid_reg;
    logic               rd_at_start_reg;

    // Arithmetic state
    logic [IB:0]          dvd_reg;
    logic [IB-1:0]        rem_reg;
    logic [OFFSET_W-1:0]  prod_reg;
    logic [OFFSET_W-1:0]  acc_reg;
    logic [OFFSET_W-1:0]  decl_reg;
    logic [OFFSET_W-1:0]  memo_reg;
    logic                 more_reg;
    logic                 adv_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic [OFFSET_W-1:0]  out_decl_reg;
    logic [OFFSET_W-1:0]  out_memo_reg;
    logic                 out_more_reg;
    logic                 out_adv_reg;

    logic [IB-1:0]        ld_start;
    logic [IB-1:0]        ld_stride_raw;
    logic [IB-1:0]        ld_stride;
    logic [IB-1:0]        ld_stop;
    logic [IB-1:0]        ld_size;
    logic [DIM_W-1:0]     ld_addr;
    logic                 ld_in_range;
    logic                 ld_we;

    logic [IB-1:0]        start_eff;
    logic [IB-1:0]        stride_eff;
    logic [IB-1:0]        stop_eff;
    logic [IB-1:0]        size_eff;
    logic [FIELD_W-1:0]   step_eff;
    logic [IB:0]          idx_eff;

    logic [IB:0]          trial;
    logic                 trial_ge;
    logic [IB:0]          trial_sub;
    logic [IB:0]          adv_sum;
    logic                 adv_hit;

    logic [OFFSET_W-1:0]  mul_a;
    logic [OFFSET_W-1:0]  mul_b;
    logic [31:0]          mul_x;
    logic [31:0]          mul_y;
    logic [OFFSET_W-1:0]  mul_p;

    // Narrow load fields to the index width, a zero stride counts as one
    assign ld_start      = IB'(s_dim_start);
    assign ld_stride_raw = IB'(s_dim_stride);
    assign ld_stride     = (ld_stride_raw == '0) ? IB'(1) : ld_stride_raw;
    assign ld_stop       = IB'(s_dim_stop);
    assign ld_size       = IB'(s_dim_declared_size);
    assign ld_addr       = DIM_W'(s_dim_index);
    assign ld_in_range   = (int'(s_dim_index) < int'(MAX_DIMS));
    assign ld_we         = cmd.load_we && ld_in_range;

    // Table writes and registered reads
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            param_mem[ld_addr] <= {s_dim_mem_step, ld_size, ld_stop, ld_stride, ld_start};
        end
        if (cmd.rd_en) begin
            rd_param_reg <= param_mem[dim_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.adv_apply && (adv_hit || dim_addr == '0)) begin
            idx_mem[dim_addr] <= adv_sum;
        end
        if (cmd.rd_en) begin
            rd_idx_reg      <= idx_mem[dim_addr];
            rd_pvalid_reg   <= param_valid_reg[dim_addr];
            rd_at_start_reg <= at_start_reg[dim_addr];
        end
    end

    // Valid and at-start flags stand in for clearing the tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            param_valid_reg <= '0;
            at_start_reg    <= '1;
        end else begin
            if (ld_we) begin
                param_valid_reg[ld_addr] <= 1'b1;
                at_start_reg[ld_addr]    <= 1'b1;
            end
            if (cmd.restart) begin
                at_start_reg <= '1;
            end
            if (cmd.adv_apply) begin
                at_start_reg[dim_addr] <= !(adv_hit || dim_addr == '0);
            end
        end
    end

    // Entries never loaded read as their reset values
    always_comb begin
        if (rd_pvalid_reg) begin
            start_eff  = rd_param_reg[OFF_START  +: IB];
            stride_eff = rd_param_reg[OFF_STRIDE +: IB];
            stop_eff   = rd_param_reg[OFF_STOP   +: IB];
            size_eff   = rd_param_reg[OFF_SIZE   +: IB];
            step_eff   = rd_param_reg[OFF_STEP   +: FIELD_W];
        end else begin
            start_eff  = '0;
            stride_eff = IB'(1);
            stop_eff   = '0;
            size_eff   = '0;
            step_eff   = '0;
        end
        idx_eff = rd_at_start_reg ? {1'b0, start_eff} : rd_idx_reg;
    end

    // Restoring divider step and odometer increment
    assign trial     = {rem_reg, dvd_reg[IB]};
    assign trial_ge  = (trial >= {1'b0, stride_eff});
    assign trial_sub = trial - {1'b0, stride_eff};
    assign adv_sum   = idx_eff + {1'b0, stride_eff};
    assign adv_hit   = (adv_sum < {1'b0, stop_eff});

    // Operand selection for the shared 32x32 multiplier
    always_comb begin
        if (cmd.mul_sel == MUL_MEM) begin
            mul_a = OFFSET_W'(dvd_reg);
            mul_b = {{(OFFSET_W - FIELD_W){step_eff[FIELD_W-1]}}, step_eff};
        end else begin
            mul_a = decl_reg;
            mul_b = OFFSET_W'(size_eff);
        end
        unique case (cmd.mul_phase)
            MUL_PH_LO: begin
                mul_x = mul_a[31:0];
                mul_y = mul_b[31:0];
            end
            MUL_PH_X1: begin
                mul_x = mul_a[31:0];
                mul_y = mul_b[63:32];
            end
            MUL_PH_X2: begin
                mul_x = mul_a[63:32];
                mul_y = mul_b[31:0];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    // Per-item arithmetic registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            more_reg <= 1'b0;
            adv_reg  <= 1'b0;
        end else begin
            if (cmd.step_start) begin
                more_reg <= 1'b0;
                adv_reg  <= 1'b0;
            end
            if (cmd.chk && dim_addr == '0) begin
                more_reg <= (idx_eff < {1'b0, stop_eff});
            end
            if (cmd.adv_apply && (adv_hit || dim_addr == '0)) begin
                adv_reg <= adv_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_start) begin
            decl_reg <= '0;
            memo_reg <= '0;
        end
        // Start a division with the step count numerator
        if (cmd.div_init) begin
            dvd_reg <= idx_eff - {1'b0, start_eff};
            rem_reg <= '0;
        end
        // Shift one quotient bit in
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[IB-1:0] : trial[IB-1:0];
            dvd_reg <= {dvd_reg[IB-1:0], trial_ge};
        end
        // Accumulate partial products, then commit
        if (cmd.mul_en) begin
            unique case (cmd.mul_phase)
                MUL_PH_LO: begin
                    prod_reg <= mul_p;
                end
                MUL_PH_X1: begin
                    acc_reg  <= prod_reg;
                    prod_reg <= {mul_p[31:0], 32'd0};
                end
                MUL_PH_X2: begin
                    acc_reg  <= acc_reg + prod_reg;
                    prod_reg <= {mul_p[31:0], 32'd0};
                end
                MUL_PH_SUM: begin
                    acc_reg <= acc_reg + prod_reg;
                end
                MUL_PH_COMMIT: begin
                    if (cmd.mul_sel == MUL_MEM) begin
                        memo_reg <= memo_reg + acc_reg;
                    end else begin
                        decl_reg <= acc_reg + OFFSET_W'(idx_eff);
                    end
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    // Result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_decl_reg <= decl_reg;
            out_memo_reg <= memo_reg;
            out_more_reg <= more_reg;
            out_adv_reg  <= adv_reg;
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign m_declared_offset = out_decl_reg;
    assign m_memory_offset   = out_memo_reg;
    assign m_more            = out_more_reg;
    assign m_advanced        = out_adv_reg;

    assign sts.more     = more_reg;
    assign sts.adv_hit  = adv_hit;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    `SNIO_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_tvalid_reg || m_tready, "result beat overwritten")
    `SNIO_ASSERT_NEXT(a_restart_all, aclk, aresetn, cmd.restart, &at_start_reg, "restart left an index off its start")
    `SNIO_ASSERT_NEXT(a_carry_rewinds, aclk, aresetn, cmd.adv_apply && !adv_hit && dim_addr != '0, at_start_reg[$past(dim_addr)], "carry did not rewind the dimension")

endmodule

[src/snio_ctrl.sv]
`include "strided_nd_index_odometer_assert.svh"

module snio_ctrl #(
    parameter int unsigned MAX_DIMS   = snio_pkg::SNIO_MAX_DIMS,
    parameter int unsigned INDEX_BITS = snio_pkg::SNIO_INDEX_BITS,
    parameter int unsigned DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  snio_pkg::cmd_code_t          s_command,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [snio_pkg::RANK_W-1:0]  cfg_data,
    output snio_pkg::dp_cmd_t            cmd,
    output logic [DIM_W-1:0]             dim_addr,
    input  snio_pkg::dp_sts_t            sts
);
    import snio_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIMS + 1);
    localparam int unsigned CTR_W = $clog2(INDEX_BITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_ARD  = 3'd5;
    localparam logic [2:0] ST_ACHK = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  dim_reg, dim_next;
    logic [CTR_W-1:0]  cnt_reg, cnt_next;
    logic              sel_reg, sel_next;
    logic [RANK_W-1:0] rank_reg;
    logic [CNT_W-1:0]  n_dims;
    logic [CNT_W-1:0]  dim_inc;

    // Dimensions in use saturate at the table depth
    assign n_dims   = (int'(rank_reg) > int'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : CNT_W'(rank_reg);
    assign dim_inc  = dim_reg + CNT_W'(1);
    assign dim_addr = dim_reg[DIM_W-1:0];

    assign cfg_ready = (state_reg == ST_IDLE);

    // Rank register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            rank_reg <= cfg_data;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        dim_next   = dim_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.mul_sel   = sel_reg;
        cmd.mul_phase = cnt_reg[MUL_PH_W-1:0];
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_we = (s_command == CMD_LOAD);
                    cmd.restart = (s_command == CMD_RESTART);
                    if (s_command == CMD_STEP) begin
                        cmd.step_start = 1'b1;
                        dim_next       = '0;
                        state_next     = ST_RD;
                    end
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk = 1'b1;
                if (dim_reg < n_dims) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CTR_W'(INDEX_BITS)) begin
                    cnt_next   = '0;
                    sel_next   = MUL_DECL;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + CTR_W'(1);
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == CTR_W'(MUL_PH_COMMIT)) begin
                    cnt_next = '0;
                    if (sel_reg == MUL_DECL) begin
                        sel_next = MUL_MEM;
                    end else if (dim_inc < n_dims) begin
                        dim_next   = dim_inc;
                        state_next = ST_RD;
                    end else if (sts.more) begin
                        dim_next   = n_dims - CNT_W'(1);
                        state_next = ST_ARD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    cnt_next = cnt_reg + CTR_W'(1);
                end
            end
            ST_ARD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_ACHK;
            end
            ST_ACHK: begin
                cmd.adv_apply = 1'b1;
                if (sts.adv_hit || dim_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    dim_next   = dim_reg - CNT_W'(1);
                    state_next = ST_ARD;
                end
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dim_reg   <= '0;
            cnt_reg   <= '0;
            sel_reg   <= MUL_DECL;
        end else begin
            state_reg <= state_next;
            dim_reg   <= dim_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    `SNIO_ASSERT_NOW(a_div_in_rank, aclk, aresetn, state_reg == ST_DIV, dim_reg < n_dims, "division outside the dimensions in use")
    `SNIO_ASSERT_NOW(a_div_count, aclk, aresetn, state_reg == ST_DIV, cnt_reg <= CTR_W'(INDEX_BITS), "divider ran past its last bit")
    `SNIO_ASSERT_NEXT(a_apply_then, aclk, aresetn, state_reg == ST_ACHK, state_reg == ST_ARD || state_reg == ST_EMIT, "advance step went astray")

endmodule

[src/strided_nd_index_odometer.sv]
// Load and restart beats keep the block idle; the next beat is taken the cycle after.
// A step beat is handled one dimension in use at a time: a radix-2 divider finds the
// step count, then one shared 32x32 multiplier forms the declared and memory offsets;
// while more remains, the advance then walks the dimensions from the last one down.
// One item is in flight at a time; a waiting result does not block acceptance.
// aresetn is synchronous, active low: rank 1, all table entries read as reset values.
module strided_nd_index_odometer #(
    parameter int unsigned MAX_DIMS   = snio_pkg::SNIO_MAX_DIMS,
    parameter int unsigned INDEX_BITS = snio_pkg::SNIO_INDEX_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // dim_index[2:0], dim_start[34:3], dim_stride[66:35], dim_stop[98:67],
    // dim_declared_size[130:99], dim_mem_step[162:131], zero fill above
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [snio_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [snio_pkg::CMD_W-1:0]      s_tuser,
    // declared_offset[63:0], memory_offset[127:64], more[128], advanced[129], zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [snio_pkg::M_TDATA_W-1:0]  m_tdata,
    // rank write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [snio_pkg::RANK_W-1:0]     cfg_data
);
    import snio_pkg::*;

    localparam int unsigned DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    dp_cmd_t               cmd;
    dp_sts_t               sts;
    logic [DIM_W-1:0]      dim_addr;
    logic [OFFSET_W-1:0]   m_declared_offset;
    logic [OFFSET_W-1:0]   m_memory_offset;
    logic                  m_more;
    logic                  m_advanced;

    snio_ctrl #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS),
        .DIM_W      (DIM_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .dim_addr  (dim_addr),
        .sts       (sts)
    );

    snio_dpath #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS),
        .DIM_W      (DIM_W)
    ) u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .dim_addr            (dim_addr),
        .sts                 (sts),
        .s_dim_index         (s_tdata[2:0]),
        .s_dim_start         (s_tdata[34:3]),
        .s_dim_stride        (s_tdata[66:35]),
        .s_dim_stop          (s_tdata[98:67]),
        .s_dim_declared_size (s_tdata[130:99]),
        .s_dim_mem_step      (s_tdata[162:131]),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_declared_offset   (m_declared_offset),
        .m_memory_offset     (m_memory_offset),
        .m_more              (m_more),
        .m_advanced          (m_advanced)
    );

    // Pack the result beat, zero fill to whole bytes
    assign m_tdata = {{(M_TDATA_W - M_TDATA_RAW){1'b0}},
                      m_advanced, m_more, m_memory_offset, m_declared_offset};

endmodule
